FILE: rtl/sorted_table_linear_interpolator_macros.svh
// Assertion macros for the sorted breakpoint interpolator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define STI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sti_pkg.sv
// Package for the sorted breakpoint interpolator: sizes, func codes, cell link types.
// No dependencies.
`default_nettype none
package sti_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DEN_W       = 17;
    localparam int NUM_W       = 35;
    localparam int STEP_W      = $clog2(NUM_W + 1);

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] coeff;
        logic               le;
        logic               eq;
    } t_link;

    typedef struct packed {
        logic hit;
        logic lo;
        logic gt;
    } t_flags;
endpackage
`default_nettype wire

FILE: rtl/sti_if.sv
// Handshake channels of the interpolator: input item and result item.
// Depends on nothing.
`default_nettype none
interface sti_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic signed [15:0] angle_in;
    logic signed [15:0] coeff_in;
    modport source (output valid, func, angle_in, coeff_in, input ready);
    modport sink   (input valid, func, angle_in, coeff_in, output ready);
endinterface

interface sti_out_if;
    logic               valid;
    logic               ready;
    logic               in_range;
    logic signed [15:0] coeff_out;
    modport source (output valid, in_range, coeff_out, input ready);
    modport sink   (input valid, in_range, coeff_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/sti_cell.sv
// One table cell: holds one breakpoint, compares it to the key, shifts on insert.
// Depends on sti_pkg.
`default_nettype none
module sti_cell (
    input  wire                 i_clk,
    input  wire                 i_valid,
    input  wire                 i_ins,
    input  wire signed [15:0]   i_key,
    input  wire signed [15:0]   i_new_coeff,
    input  wire sti_pkg::t_link i_prev,
    input  wire                 i_next_gt,
    output sti_pkg::t_link      o_link,
    output sti_pkg::t_flags     o_flags
);
    import sti_pkg::*;

    logic signed [15:0] r_angle, r_coeff;
    logic signed [15:0] n_angle, n_coeff;
    logic le, lt, eq;

    assign le = i_valid && (r_angle <= i_key);
    assign lt = i_valid && (r_angle <  i_key);
    assign eq = i_valid && (r_angle == i_key);

    assign o_link  = '{angle: r_angle, coeff: r_coeff, le: le, eq: eq};
    assign o_flags = '{hit: eq && !i_prev.eq,
                       lo:  lt && i_next_gt,
                       gt:  i_valid && (r_angle > i_key)};

    always_comb begin
        n_angle = r_angle;
        n_coeff = r_coeff;
        if (i_ins && !le) begin
            if (i_prev.le) begin
                n_angle = i_key;
                n_coeff = i_new_coeff;
            end else begin
                n_angle = i_prev.angle;
                n_coeff = i_prev.coeff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
        r_coeff <= n_coeff;
    end
endmodule
`default_nettype wire

FILE: rtl/sti_div.sv
// Restoring divider, one quotient bit per cycle, signed numerator, positive divisor.
// Depends on sti_pkg.
`default_nettype none
module sti_div (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire signed [sti_pkg::NUM_W-1:0] i_num,
    input  wire        [sti_pkg::DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [15:0]      o_quo
);
    import sti_pkg::*;

    logic              r_busy, r_neg;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_den, r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic [NUM_W-1:0]  quo_s;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign o_done = r_busy && (r_step == STEP_W'(NUM_W));
    assign quo_s  = r_neg ? (~r_quo + NUM_W'(1)) : r_quo;
    assign o_quo  = quo_s[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_quo <= i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && !o_done) begin
            if (!diff[DEN_W]) begin
                r_rem <= diff[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/sorted_table_linear_interpolator.sv
// Sorted breakpoint table with linear interpolation over a row of cells.
// Clear and insert take effect in the accepting cycle; the next item can be taken in the cycle after.
// A query that hits a breakpoint or falls outside the span goes through SCAN and DONE; an
// interpolated one goes through SCAN, MUL, SUM, DIV and DONE, waiting on the 35-step
// bit-serial divider. The input is freed once the result is loaded. One query at a time.
// Synchronous active-low reset empties the table; no clearing pass.
`default_nettype none
`include "sorted_table_linear_interpolator_macros.svh"
module sorted_table_linear_interpolator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sti_in_if.sink     in_ch,
    sti_out_if.source  out_ch
);
    import sti_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0]   r_count;
    logic signed [15:0] r_x, key;
    logic               accept, ins;

    t_link  w_link [TABLE_DEPTH];
    t_flags w_flags[TABLE_DEPTH];

    logic               any_hit, any_lo;
    logic signed [15:0] sel_c, a0, c0, a1, c1;
    logic               r_hit, r_lo;
    logic signed [15:0] r_hc, r_a0, r_c0, r_a1, r_c1;
    logic signed [16:0] span, dx, dc, c0x;
    logic signed [33:0] r_p1, r_p2;
    logic [DEN_W-1:0]   r_den;
    logic               div_start, div_done;
    logic signed [15:0] div_quo;

    logic               r_out_valid, r_out_range;
    logic signed [15:0] r_out_coeff;
    logic               load_out;

    assign in_ch.ready = (r_state == ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign ins = accept && (in_ch.func == FUNC_INSERT) && (r_count < CNT_W'(TABLE_DEPTH));
    assign key = (r_state == ST_IDLE) ? in_ch.angle_in : r_x;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            t_link prev;
            logic  next_gt;
            if (g == 0) begin : g_first
                assign prev = '{angle: '0, coeff: '0, le: 1'b1, eq: 1'b0};
            end else begin : g_mid
                assign prev = w_link[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign next_gt = 1'b0;
            end else begin : g_nxt
                assign next_gt = w_flags[g+1].gt;
            end
            sti_cell u_cell (
                .i_clk       (i_clk),
                .i_valid     (CNT_W'(g) < r_count),
                .i_ins       (ins),
                .i_key       (key),
                .i_new_coeff (in_ch.coeff_in),
                .i_prev      (prev),
                .i_next_gt   (next_gt),
                .o_link      (w_link[g]),
                .o_flags     (w_flags[g])
            );
        end
    endgenerate

    always_comb begin
        any_hit = 1'b0;
        any_lo  = 1'b0;
        sel_c = '0; a0 = '0; c0 = '0; a1 = '0; c1 = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_flags[i].hit) begin
                any_hit = 1'b1;
                sel_c   = sel_c | w_link[i].coeff;
            end
            if (w_flags[i].lo && (i < TABLE_DEPTH - 1)) begin
                any_lo = 1'b1;
                a0 = a0 | w_link[i].angle;
                c0 = c0 | w_link[i].coeff;
                a1 = a1 | w_link[(i + 1) % TABLE_DEPTH].angle;
                c1 = c1 | w_link[(i + 1) % TABLE_DEPTH].coeff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept && (in_ch.func == FUNC_CLEAR)) begin
            r_count <= '0;
        end else if (ins) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (accept && (in_ch.func == FUNC_QUERY)) r_state <= ST_SCAN;
                ST_SCAN: r_state <= (any_lo && !any_hit) ? ST_MUL : ST_DONE;
                ST_MUL:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_DIV;
                ST_DIV:  if (div_done) r_state <= ST_DONE;
                ST_DONE: if (load_out) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // 17-bit signed operands of the two products
    assign span = {r_a1[15], r_a1} - {r_a0[15], r_a0};
    assign dx   = {r_x[15], r_x} - {r_a0[15], r_a0};
    assign dc   = {r_c1[15], r_c1} - {r_c0[15], r_c0};
    assign c0x  = {r_c0[15], r_c0};

    always_ff @(posedge i_clk) begin
        if (accept) r_x <= in_ch.angle_in;
        if (r_state == ST_SCAN) begin
            r_hit <= any_hit;
            r_lo  <= any_lo && !any_hit;
            r_hc  <= sel_c;
            r_a0  <= a0; r_c0 <= c0; r_a1 <= a1; r_c1 <= c1;
        end
        if (r_state == ST_MUL) begin
            r_p1  <= 34'(c0x) * 34'(span);
            r_p2  <= 34'(dx) * 34'(dc);
            r_den <= DEN_W'(span);
        end
    end

    assign div_start = (r_state == ST_SUM);
    sti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NUM_W'($signed({r_p1[33], r_p1}) + $signed({r_p2[33], r_p2}))),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    logic signed [15:0] r_res;
    always_ff @(posedge i_clk) begin
        if (div_done) r_res <= div_quo;
    end

    assign load_out = (r_state == ST_DONE) && (!r_out_valid || out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_range <= r_hit || r_lo;
            r_out_coeff <= r_hit ? r_hc : (r_lo ? r_res : 16'sd0);
        end
    end

    assign out_ch.valid     = r_out_valid;
    assign out_ch.in_range  = r_out_range;
    assign out_ch.coeff_out = r_out_coeff;

    `STI_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(r_state), "state not one-hot")
    `STI_ASSERT_IMP(a_count_max, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "entry count overflow")
    `STI_ASSERT_IMP(a_interp_no_hit, r_state == ST_MUL, !r_hit && r_lo, "interp with exact hit")
    `STI_ASSERT_NXT(a_ins_grows, ins, r_count == $past(r_count) + CNT_W'(1), "insert lost")
    `STI_ASSERT_IMP(a_den_pos, r_state == ST_SUM, r_den != '0, "zero bracket width")
endmodule
`default_nettype wire
